/* rtl/core/cxy_pkg.sv */
// shared types, register indexes and pipeline depths of the corexy/uv converter
`timescale 1ns / 1ps

package cxy_pkg;

    // field and register widths
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;

    // steps-to-mm quotient bits: |steps| * 2^28 plus half the divisor fits 60 bits
    localparam int DIVQ_W = 60;
    // position-to-result quotient bits kept before saturation
    localparam int FDIV_W = 32;
    // signed width of a lane value and of the pair sum and difference
    localparam int VAL_W  = 62;
    // magnitude width before the 32-bit clamp
    localparam int MAG_W  = 53;

    // pipeline depths
    localparam int SCALE_LAT = DIVQ_W + 2;
    localparam int OUT_LAT   = FDIV_W + 3;
    localparam int TOTAL_LAT = SCALE_LAT + 1 + OUT_LAT;

    // conversion direction
    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_FACTOR = 3'd0,
        CFG_Y_FACTOR = 3'd1,
        CFG_U_FACTOR = 3'd2,
        CFG_V_FACTOR = 3'd3,
        CFG_X_SPM    = 3'd4,
        CFG_Y_SPM    = 3'd5,
        CFG_U_SPM    = 3'd6,
        CFG_V_SPM    = 3'd7
    } cfg_index_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_ZERO_DIV = 2'd2
    } status_t;

    // input beat
    typedef struct packed {
        logic                     mode;
        logic signed [WORD_W-1:0] x_value;
        logic signed [WORD_W-1:0] y_value;
        logic signed [WORD_W-1:0] u_value;
        logic signed [WORD_W-1:0] v_value;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic signed [WORD_W-1:0] x_result;
        logic signed [WORD_W-1:0] y_result;
        logic signed [WORD_W-1:0] u_result;
        logic signed [WORD_W-1:0] v_result;
        status_t                  status;
    } out_beat_t;

    // scaled axis value from a front lane
    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] value;
    } scale_out_t;

    // clamped result from a back lane
    typedef struct packed {
        logic                     mode;
        logic signed [WORD_W-1:0] result;
        logic                     sat;
    } lane_res_t;

endpackage

/* rtl/core/cxy_scale_lane.sv */
// front lane: position times axis factor, or steps over steps per mm
`timescale 1ns / 1ps

module cxy_scale_lane (
    input  logic                                    aclk,
    input  logic                                    ce,
    input  logic                                    mode_in,
    input  logic signed [cxy_pkg::WORD_W-1:0]       value_in,
    input  logic signed [cxy_pkg::WORD_W-1:0]       factor,
    input  logic        [cxy_pkg::WORD_W-1:0]       spm,
    output cxy_pkg::scale_out_t                     lane_out
);

    localparam int N  = cxy_pkg::DIVQ_W;
    localparam int W  = cxy_pkg::WORD_W;

    logic                    mode_reg [0:N];
    logic                    neg_reg  [0:N];
    logic        [W-1:0]     rem_reg  [0:N];
    logic        [N-1:0]     acc_reg  [0:N];
    logic signed [2*W-1:0]   prod_reg;
    logic signed [47:0]      fwd_reg  [1:N];
    cxy_pkg::scale_out_t     out_reg;

    logic        [W-1:0]     mag_in;
    logic signed [2*W-1:0]   prod_rnd;
    logic        [cxy_pkg::VAL_W-1:0] q_ext;

    // magnitude of a step count, -2^31 maps to 2^31
    assign mag_in   = value_in[W-1] ? (~value_in + 1'b1) : value_in;
    // product rounded to Q.12, half toward plus infinity
    assign prod_rnd = (prod_reg + 64'sd32768) >>> 16;

    // input stage: multiplier and divider setup
    always_ff @(posedge aclk) begin
        if (ce) begin
            mode_reg[0] <= mode_in;
            neg_reg[0]  <= value_in[W-1];
            prod_reg    <= value_in * factor;
            rem_reg[0]  <= '0;
            acc_reg[0]  <= {mag_in, 28'd0} + N'(spm >> 1);
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [W:0] rem_sh;
        logic       take;
        assign rem_sh = {rem_reg[k], acc_reg[k][N-1]};
        assign take   = rem_sh >= {1'b0, spm};
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1] <= take ? W'(rem_sh - {1'b0, spm}) : rem_sh[W-1:0];
                acc_reg[k+1] <= {acc_reg[k][N-2:0], take};
                mode_reg[k+1] <= mode_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
            end
        end
    end

    // forward value rides alongside the divider
    always_ff @(posedge aclk) begin
        if (ce) begin
            fwd_reg[1] <= prod_rnd[47:0];
            for (int k = 1; k < N; k++) begin
                fwd_reg[k+1] <= fwd_reg[k];
            end
        end
    end

    assign q_ext = {2'b00, acc_reg[N]};

    // output register: pick the mode's value
    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg.mode <= mode_reg[N];
            if (mode_reg[N] == cxy_pkg::MODE_INV) begin
                out_reg.value <= neg_reg[N] ? -$signed(q_ext) : $signed(q_ext);
            end else begin
                out_reg.value <= cxy_pkg::VAL_W'(fwd_reg[N]);
            end
        end
    end

    assign lane_out = out_reg;

endmodule

/* rtl/core/cxy_out_lane.sv */
// back lane: pair value to motor steps, or over the axis factor, then clamp
`timescale 1ns / 1ps

module cxy_out_lane (
    input  logic                                    aclk,
    input  logic                                    ce,
    input  logic                                    mode_in,
    input  logic signed [cxy_pkg::VAL_W-1:0]        d_in,
    input  logic        [cxy_pkg::WORD_W-1:0]       spm,
    input  logic signed [cxy_pkg::WORD_W-1:0]       factor,
    input  logic                                    kill,
    output cxy_pkg::lane_res_t                      lane_out
);

    localparam int N = cxy_pkg::FDIV_W;
    localparam int W = cxy_pkg::WORD_W;
    localparam int M = cxy_pkg::MAG_W;

    logic                        mode0_reg;
    logic                        neg0_reg;
    logic [cxy_pkg::VAL_W-1:0]   mag0_reg;

    logic [2*W-1:0]              p_lo_reg;
    logic [47:0]                 p_hi_reg;

    logic                        mode_reg [0:N];
    logic                        neg_reg  [0:N];
    logic                        ovf_reg  [0:N];
    logic [W-1:0]                rem_reg  [0:N];
    logic [N-1:0]                acc_reg  [0:N];
    logic [M-1:0]                fwd_reg  [1:N];

    cxy_pkg::lane_res_t          out_reg;

    logic [W-1:0]                mf;
    logic                        ovf;
    logic [2*W:0]                lo_rnd;
    logic [M-1:0]                q_fwd;
    logic                        rnd;
    logic [W:0]                  q_inv;
    logic [M-1:0]                mag_fin;
    logic                        sat_fin;
    logic [W-1:0]                mag32;

    // divisor magnitude, -2^31 maps to 2^31
    assign mf  = factor[W-1] ? (~factor + 1'b1) : factor;
    // a quotient of 2^32 or more saturates whatever its sign
    assign ovf = mag0_reg[cxy_pkg::VAL_W-1:17] >= (cxy_pkg::VAL_W-17)'(mf);

    // sign and magnitude
    always_ff @(posedge aclk) begin
        if (ce) begin
            mode0_reg <= mode_in;
            neg0_reg  <= d_in[cxy_pkg::VAL_W-1] ^ (mode_in & factor[W-1]);
            mag0_reg  <= d_in[cxy_pkg::VAL_W-1] ? cxy_pkg::VAL_W'(-d_in)
                                                : cxy_pkg::VAL_W'(d_in);
        end
    end

    // partial products and divider setup
    always_ff @(posedge aclk) begin
        if (ce) begin
            p_lo_reg    <= 64'(mag0_reg[31:0]) * 64'(spm);
            p_hi_reg    <= 48'(mag0_reg[47:32]) * 48'(spm);
            mode_reg[0] <= mode0_reg;
            neg_reg[0]  <= neg0_reg;
            ovf_reg[0]  <= ovf;
            rem_reg[0]  <= ovf ? '0 : mag0_reg[48:17];
            acc_reg[0]  <= {mag0_reg[16:0], 15'd0};
        end
    end

    // steps rounded half away from zero on the magnitude
    assign lo_rnd = 65'(p_lo_reg) + 65'd134217728;
    assign q_fwd  = M'({p_hi_reg, 4'd0}) + M'(lo_rnd[2*W:28]);

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [W:0] rem_sh;
        logic       take;
        assign rem_sh = {rem_reg[k], acc_reg[k][N-1]};
        assign take   = rem_sh >= {1'b0, mf};
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k+1]  <= take ? W'(rem_sh - {1'b0, mf}) : rem_sh[W-1:0];
                acc_reg[k+1]  <= {acc_reg[k][N-2:0], take};
                mode_reg[k+1] <= mode_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    // forward steps ride alongside the divider
    always_ff @(posedge aclk) begin
        if (ce) begin
            fwd_reg[1] <= q_fwd;
            for (int k = 1; k < N; k++) begin
                fwd_reg[k+1] <= fwd_reg[k];
            end
        end
    end

    // quotient rounding, half away from zero
    assign rnd   = {rem_reg[N], 1'b0} >= {1'b0, mf};
    assign q_inv = (W+1)'(acc_reg[N]) + (W+1)'(rnd);

    always_comb begin
        if (mode_reg[N] == cxy_pkg::MODE_INV) begin
            mag_fin = ovf_reg[N] ? M'(53'h100_0000_0000) : M'(q_inv);
        end else begin
            mag_fin = fwd_reg[N];
        end
        if (neg_reg[N]) begin
            sat_fin = mag_fin > M'(32'h8000_0000);
            mag32   = sat_fin ? 32'h8000_0000 : mag_fin[W-1:0];
        end else begin
            sat_fin = mag_fin > M'(32'h7FFF_FFFF);
            mag32   = sat_fin ? 32'h7FFF_FFFF : mag_fin[W-1:0];
        end
    end

    // output register, forced to zero on a zero divisor
    always_ff @(posedge aclk) begin
        if (ce) begin
            out_reg.mode <= mode_reg[N];
            if (kill && mode_reg[N] == cxy_pkg::MODE_INV) begin
                out_reg.result <= '0;
                out_reg.sat    <= 1'b0;
            end else begin
                out_reg.result <= neg_reg[N] ? -$signed(mag32) : $signed(mag32);
                out_reg.sat    <= sat_fin;
            end
        end
    end

    assign lane_out = out_reg;

endmodule

/* rtl/core/corexyuv_position_step_convert.sv */
// top level: config registers, four front lanes, pair merge, four back lanes, status
`timescale 1ns / 1ps

// Converts XY and UV gantry positions (Q20.12 mm) to CoreXY motor steps when
// mode is 0, and motor steps back to positions when mode is 1. The block takes
// one beat per clock; its depth comes from the 60-stage steps-to-mm divider
// in the front lanes and the 32-stage factor divider in the back lanes, one
// quotient bit per stage. The whole pipeline advances whenever the output
// register is empty or being taken, so s_ready falls only while a result
// waits. The user must write configuration through cfg_wr_en/cfg_addr/
// cfg_wr_data only while no beat is in flight; the block does not enforce it.

module corexyuv_position_step_convert (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cxy_pkg::in_beat_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cxy_pkg::out_beat_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [cxy_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [cxy_pkg::WORD_W-1:0]          cfg_wr_data
);

    localparam int L = cxy_pkg::TOTAL_LAT;

    logic signed [cxy_pkg::WORD_W-1:0] x_factor_reg, y_factor_reg;
    logic signed [cxy_pkg::WORD_W-1:0] u_factor_reg, v_factor_reg;
    logic        [cxy_pkg::WORD_W-1:0] x_spm_reg, y_spm_reg, u_spm_reg, v_spm_reg;

    logic                              valid_reg [0:L-1];
    logic                              ce;

    cxy_pkg::scale_out_t               x_scl, y_scl, u_scl, v_scl;
    logic                              mode_sum_reg;
    logic signed [cxy_pkg::VAL_W-1:0]  xy_sum_reg, xy_dif_reg, uv_sum_reg, uv_dif_reg;
    cxy_pkg::lane_res_t                x_res, y_res, u_res, v_res;

    logic                              xy_spm_zero, uv_spm_zero, zero_cfg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_factor_reg <= 32'sd65536;
            y_factor_reg <= 32'sd65536;
            u_factor_reg <= 32'sd65536;
            v_factor_reg <= 32'sd65536;
            x_spm_reg    <= 32'd5242880;
            y_spm_reg    <= 32'd5242880;
            u_spm_reg    <= 32'd5242880;
            v_spm_reg    <= 32'd5242880;
        end else if (cfg_wr_en) begin
            case (cxy_pkg::cfg_index_t'(cfg_addr))
                cxy_pkg::CFG_X_FACTOR: x_factor_reg <= cfg_wr_data;
                cxy_pkg::CFG_Y_FACTOR: y_factor_reg <= cfg_wr_data;
                cxy_pkg::CFG_U_FACTOR: u_factor_reg <= cfg_wr_data;
                cxy_pkg::CFG_V_FACTOR: v_factor_reg <= cfg_wr_data;
                cxy_pkg::CFG_X_SPM:    x_spm_reg    <= cfg_wr_data;
                cxy_pkg::CFG_Y_SPM:    y_spm_reg    <= cfg_wr_data;
                cxy_pkg::CFG_U_SPM:    u_spm_reg    <= cfg_wr_data;
                cxy_pkg::CFG_V_SPM:    v_spm_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and beat tracking
    assign ce      = !valid_reg[L-1] || m_ready;
    assign s_ready = ce;
    assign m_valid = valid_reg[L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < L; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k < L; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // front lanes, one per axis
    cxy_scale_lane u_scale_x (
        .aclk(aclk), .ce(ce), .mode_in(s_data.mode), .value_in(s_data.x_value),
        .factor(x_factor_reg), .spm(x_spm_reg), .lane_out(x_scl)
    );
    cxy_scale_lane u_scale_y (
        .aclk(aclk), .ce(ce), .mode_in(s_data.mode), .value_in(s_data.y_value),
        .factor(y_factor_reg), .spm(y_spm_reg), .lane_out(y_scl)
    );
    cxy_scale_lane u_scale_u (
        .aclk(aclk), .ce(ce), .mode_in(s_data.mode), .value_in(s_data.u_value),
        .factor(u_factor_reg), .spm(u_spm_reg), .lane_out(u_scl)
    );
    cxy_scale_lane u_scale_v (
        .aclk(aclk), .ce(ce), .mode_in(s_data.mode), .value_in(s_data.v_value),
        .factor(v_factor_reg), .spm(v_spm_reg), .lane_out(v_scl)
    );

    // pair merge: sum and difference
    always_ff @(posedge aclk) begin
        if (ce) begin
            mode_sum_reg <= x_scl.mode;
            xy_sum_reg   <= x_scl.value + y_scl.value;
            xy_dif_reg   <= x_scl.value - y_scl.value;
            uv_sum_reg   <= u_scl.value + v_scl.value;
            uv_dif_reg   <= u_scl.value - v_scl.value;
        end
    end

    // zero divisors in inverse mode
    assign xy_spm_zero = (x_spm_reg == '0) || (y_spm_reg == '0);
    assign uv_spm_zero = (u_spm_reg == '0) || (v_spm_reg == '0);
    assign zero_cfg    = xy_spm_zero || uv_spm_zero
                      || (x_factor_reg == '0) || (y_factor_reg == '0)
                      || (u_factor_reg == '0) || (v_factor_reg == '0);

    // back lanes, one per result
    cxy_out_lane u_out_x (
        .aclk(aclk), .ce(ce), .mode_in(mode_sum_reg), .d_in(xy_sum_reg),
        .spm(x_spm_reg), .factor(x_factor_reg),
        .kill(xy_spm_zero || (x_factor_reg == '0)), .lane_out(x_res)
    );
    cxy_out_lane u_out_y (
        .aclk(aclk), .ce(ce), .mode_in(mode_sum_reg), .d_in(xy_dif_reg),
        .spm(y_spm_reg), .factor(y_factor_reg),
        .kill(xy_spm_zero || (y_factor_reg == '0)), .lane_out(y_res)
    );
    cxy_out_lane u_out_u (
        .aclk(aclk), .ce(ce), .mode_in(mode_sum_reg), .d_in(uv_sum_reg),
        .spm(u_spm_reg), .factor(u_factor_reg),
        .kill(uv_spm_zero || (u_factor_reg == '0)), .lane_out(u_res)
    );
    cxy_out_lane u_out_v (
        .aclk(aclk), .ce(ce), .mode_in(mode_sum_reg), .d_in(uv_dif_reg),
        .spm(v_spm_reg), .factor(v_factor_reg),
        .kill(uv_spm_zero || (v_factor_reg == '0)), .lane_out(v_res)
    );

    // result beat and merged status
    always_comb begin
        m_data.x_result = x_res.result;
        m_data.y_result = y_res.result;
        m_data.u_result = u_res.result;
        m_data.v_result = v_res.result;
        if (x_res.mode == cxy_pkg::MODE_INV && zero_cfg) begin
            m_data.status = cxy_pkg::STATUS_ZERO_DIV;
        end else if (x_res.sat || y_res.sat || u_res.sat || v_res.sat) begin
            m_data.status = cxy_pkg::STATUS_SAT;
        end else begin
            m_data.status = cxy_pkg::STATUS_OK;
        end
    end

endmodule

/* rtl/core/cxy_checker.sv */
// port checker for the converter top level, bound in below
`timescale 1ns / 1ps

module cxy_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  cxy_pkg::in_beat_t                   s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  cxy_pkg::out_beat_t                  m_data,
    input  logic                                cfg_wr_en,
    input  logic [cxy_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [cxy_pkg::WORD_W-1:0]          cfg_wr_data
);

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    // input is stalled exactly while a result waits
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the output stall");

    // a waiting result keeps its x and v results
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data.x_result)
                                && $stable(m_data.v_result))
        else $error("stalled result beat changed");

    // status of a valid result beat never shows the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("result beat carries an unused status code");

endmodule

bind corexyuv_position_step_convert cxy_checker u_cxy_checker (.*);
